// ----- sv/sed_pkg.sv -----
// Shared types, character codes and helpers for the string escape decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE1 = 8'h27;
    localparam logic [7:0] CH_QUOTE2 = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_VT  = 8'h0B;
    localparam logic [7:0] CTL_BEL = 8'h07;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HEX  = 2'd1;
    localparam logic [1:0] ERR_UNI  = 2'd2;

    localparam int unsigned MAX_RES = 4;

    typedef enum logic [5:0] {
        PH_PLAIN = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_OCT   = 6'b000100,
        PH_HEX   = 6'b001000,
        PH_UNI   = 6'b010000,
        PH_DROP  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_literal;
        logic [1:0] error_code;
    } t_result;

    // {is_digit, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sed_req_if.sv -----
// Request channels of the string escape decoder: raw input bytes and decoded results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface sed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_literal;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_literal, output error_code, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input end_of_literal, input error_code, output ready);
endinterface
`default_nettype wire

// ----- sv/string_escape_decoder_top.sv -----
// Top level of the string escape decoder: phase machine plus result slot.
// Depends on sed_pkg and the channel interfaces in sed_req_if.sv.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+------------------------------------------------
//  i_req    | in  | valid/ready | data_byte[7:0], is_last
//  o_res    | out | valid/ready | out_byte[7:0], byte_valid, end_of_literal,
//           |     |             | error_code[1:0]
//
// Each request is decoded in the cycle it is accepted into a slot of up to four
// results, which drain one per cycle while o_res.ready is high. A request that
// yields 0 or 1 results is taken each cycle unless o_res stalls; more hold the input.
// i_req.ready is high when the slot is empty or its last result is being taken.
// i_rst_n (synchronous) returns the phase machine to plain text and empties the slot.
`timescale 1ns / 1ps
`default_nettype none
module string_escape_decoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sed_in_if.sink      i_req,
    sed_out_if.source   o_res
);

    sed_pkg::t_phase  r_phase, n_phase;
    logic [15:0]      r_acc, n_acc;
    logic [2:0]       r_cnt, n_cnt;
    logic [1:0]       r_err, n_err;

    sed_pkg::t_result r_res [sed_pkg::MAX_RES];
    sed_pkg::t_result n_res [sed_pkg::MAX_RES];
    logic [2:0]       r_left, n_num;
    logic [1:0]       r_idx;

    logic             w_in_acc;
    logic             w_out_acc;

    assign w_out_acc   = o_res.valid && o_res.ready;
    assign i_req.ready = (r_left == 3'd0) || ((r_left == 3'd1) && o_res.ready);
    assign w_in_acc    = i_req.valid && i_req.ready;

    assign o_res.valid          = (r_left != 3'd0);
    assign o_res.out_byte       = r_res[r_idx].out_byte;
    assign o_res.byte_valid     = r_res[r_idx].byte_valid;
    assign o_res.end_of_literal = r_res[r_idx].end_of_literal;
    assign o_res.error_code     = r_res[r_idx].error_code;

    always_comb begin
        logic [7:0]  c;
        logic        last;
        logic [4:0]  hx;
        logic        is_oct;
        logic [15:0] sh4;
        logic [15:0] sh3;
        logic [2:0]  cnt_inc;
        logic        fall;
        logic [7:0]  bytes [sed_pkg::MAX_RES];
        logic [1:0]  nb;

        c       = i_req.data_byte;
        last    = i_req.is_last;
        hx      = sed_pkg::hex_val(c);
        is_oct  = (c >= 8'h30) && (c <= 8'h37);
        sh4     = {r_acc[11:0], hx[3:0]};
        sh3     = {r_acc[12:0], c[2:0]};
        cnt_inc = r_cnt + 3'd1;
        fall    = 1'b0;
        nb      = 2'd0;
        for (int k = 0; k < sed_pkg::MAX_RES; k++) begin
            bytes[k] = 8'h00;
        end
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_err   = r_err;

        case (r_phase)
            sed_pkg::PH_DROP: begin
            end
            sed_pkg::PH_ESC: begin
                n_phase = sed_pkg::PH_PLAIN;
                case (c)
                    sed_pkg::CH_LC_N:   begin bytes[0] = sed_pkg::CH_NL;   nb = 2'd1; end
                    sed_pkg::CH_LC_T:   begin bytes[0] = sed_pkg::CTL_TAB; nb = 2'd1; end
                    sed_pkg::CH_LC_R:   begin bytes[0] = sed_pkg::CTL_CR;  nb = 2'd1; end
                    sed_pkg::CH_LC_B:   begin bytes[0] = sed_pkg::CTL_BS;  nb = 2'd1; end
                    sed_pkg::CH_LC_F:   begin bytes[0] = sed_pkg::CTL_FF;  nb = 2'd1; end
                    sed_pkg::CH_LC_V:   begin bytes[0] = sed_pkg::CTL_VT;  nb = 2'd1; end
                    sed_pkg::CH_LC_A:   begin bytes[0] = sed_pkg::CTL_BEL; nb = 2'd1; end
                    sed_pkg::CH_BSLASH,
                    sed_pkg::CH_QUOTE1,
                    sed_pkg::CH_QUOTE2: begin bytes[0] = c; nb = 2'd1; end
                    sed_pkg::CH_NL: begin
                    end
                    sed_pkg::CH_LC_X: begin
                        n_phase = sed_pkg::PH_HEX;
                        n_acc   = 16'd0;
                        n_cnt   = 3'd0;
                    end
                    sed_pkg::CH_LC_U: begin
                        n_phase = sed_pkg::PH_UNI;
                        n_acc   = 16'd0;
                        n_cnt   = 3'd0;
                    end
                    default: begin
                        if (is_oct) begin
                            n_phase = sed_pkg::PH_OCT;
                            n_acc   = {13'd0, c[2:0]};
                            n_cnt   = 3'd1;
                        end else begin
                            bytes[0] = sed_pkg::CH_BSLASH;
                            bytes[1] = c;
                            nb       = 2'd2;
                        end
                    end
                endcase
            end
            sed_pkg::PH_OCT: begin
                if (is_oct) begin
                    n_acc = sh3;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 3'd3) begin
                        bytes[0] = sh3[7:0];
                        nb       = 2'd1;
                        n_phase  = sed_pkg::PH_PLAIN;
                    end
                end else begin
                    bytes[0] = r_acc[7:0];
                    nb       = 2'd1;
                    fall     = 1'b1;
                end
            end
            sed_pkg::PH_HEX: begin
                if (hx[4]) begin
                    n_acc = sh4;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 3'd2) begin
                        bytes[0] = sh4[7:0];
                        nb       = 2'd1;
                        n_phase  = sed_pkg::PH_PLAIN;
                    end
                end else if (r_cnt == 3'd0) begin
                    if (r_err == sed_pkg::ERR_NONE) n_err = sed_pkg::ERR_HEX;
                    n_phase = sed_pkg::PH_DROP;
                end else begin
                    bytes[0] = r_acc[7:0];
                    nb       = 2'd1;
                    fall     = 1'b1;
                end
            end
            sed_pkg::PH_UNI: begin
                if (hx[4]) begin
                    n_acc = sh4;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 3'd4) begin
                        n_phase = sed_pkg::PH_PLAIN;
                        if (sh4 < 16'h0080) begin
                            bytes[0] = sh4[7:0];
                            nb       = 2'd1;
                        end else if (sh4 < 16'h0800) begin
                            bytes[0] = 8'hC0 | {3'd0, sh4[10:6]};
                            bytes[1] = 8'h80 | {2'd0, sh4[5:0]};
                            nb       = 2'd2;
                        end else begin
                            bytes[0] = 8'hE0 | {4'd0, sh4[15:12]};
                            bytes[1] = 8'h80 | {2'd0, sh4[11:6]};
                            bytes[2] = 8'h80 | {2'd0, sh4[5:0]};
                            nb       = 2'd3;
                        end
                    end
                end else begin
                    if (r_err == sed_pkg::ERR_NONE) n_err = sed_pkg::ERR_UNI;
                    n_phase = sed_pkg::PH_DROP;
                end
            end
            default: begin
                fall = 1'b1;
            end
        endcase

        if (fall) begin
            if (c == sed_pkg::CH_BSLASH && !last) begin
                n_phase = sed_pkg::PH_ESC;
            end else begin
                n_phase   = sed_pkg::PH_PLAIN;
                bytes[nb] = c;
                nb        = nb + 2'd1;
            end
        end

        // end of literal: flush a pending octal or hex escape, or flag an incomplete one
        if (last) begin
            case (n_phase)
                sed_pkg::PH_OCT: begin
                    bytes[nb] = n_acc[7:0];
                    nb        = nb + 2'd1;
                end
                sed_pkg::PH_HEX: begin
                    if (n_cnt == 3'd0) begin
                        if (n_err == sed_pkg::ERR_NONE) n_err = sed_pkg::ERR_HEX;
                    end else begin
                        bytes[nb] = n_acc[7:0];
                        nb        = nb + 2'd1;
                    end
                end
                sed_pkg::PH_UNI: begin
                    if (n_err == sed_pkg::ERR_NONE) n_err = sed_pkg::ERR_UNI;
                end
                default: begin
                end
            endcase
        end

        for (int k = 0; k < sed_pkg::MAX_RES; k++) begin
            n_res[k].out_byte       = bytes[k];
            n_res[k].byte_valid     = (k < nb);
            n_res[k].end_of_literal = 1'b0;
            n_res[k].error_code     = sed_pkg::ERR_NONE;
        end
        n_num = {1'b0, nb};

        if (last) begin
            if (n_err == sed_pkg::ERR_NONE && nb != 2'd0) begin
                n_res[nb - 2'd1].end_of_literal = 1'b1;
            end else begin
                n_res[nb].out_byte       = 8'h00;
                n_res[nb].byte_valid     = 1'b0;
                n_res[nb].end_of_literal = 1'b1;
                n_res[nb].error_code     = n_err;
                n_num                    = {1'b0, nb} + 3'd1;
            end
            n_phase = sed_pkg::PH_PLAIN;
            n_acc   = 16'd0;
            n_cnt   = 3'd0;
            n_err   = sed_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sed_pkg::PH_PLAIN;
            r_acc   <= 16'd0;
            r_cnt   <= 3'd0;
            r_err   <= sed_pkg::ERR_NONE;
            r_left  <= 3'd0;
            r_idx   <= 2'd0;
        end else begin
            if (w_in_acc) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_err   <= n_err;
                r_left  <= n_num;
                r_idx   <= 2'd0;
            end else if (w_out_acc) begin
                r_left <= r_left - 3'd1;
                r_idx  <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int k = 0; k < sed_pkg::MAX_RES; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/sed_checker.sv -----
// Port-level checks for string_escape_decoder_top, attached by bind.
// Depends on sed_pkg for the error codes.
`timescale 1ns / 1ps
`default_nettype none
module sed_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_byte,
    input wire       i_byte_valid,
    input wire       i_end_of_literal,
    input wire [1:0] i_error_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_byte_valid)
             && $stable(i_end_of_literal) && $stable(i_error_code)))
        else $error("result changed while stalled");

    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error_code != sed_pkg::ERR_NONE) |->
            (i_end_of_literal && !i_byte_valid))
        else $error("error code on a result that is not a bare end marker");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_byte_valid) |-> i_end_of_literal)
        else $error("bare marker without end of literal");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_code == sed_pkg::ERR_NONE
            || i_error_code == sed_pkg::ERR_HEX || i_error_code == sed_pkg::ERR_UNI))
        else $error("undefined error code");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_byte       (o_res.out_byte),
    .i_byte_valid     (o_res.byte_valid),
    .i_end_of_literal (o_res.end_of_literal),
    .i_error_code     (o_res.error_code)
);
`default_nettype wire

// ----- tb/sv/sed_decode_checker.sv -----
// Checker for the string escape decoder: watches both request channels, decodes
// every accepted input byte itself and compares the decoded results in order.
// Depends on sed_pkg and the channel interfaces in sed_req_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module sed_decode_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    sed_in_if    i_req,
    sed_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_ends,
    output int   o_errors
);

    localparam logic [7:0] CHR_0  = 8'h30;
    localparam logic [7:0] CHR_7  = 8'h37;
    localparam logic [7:0] CHR_9  = 8'h39;
    localparam logic [7:0] CHR_LA = 8'h61;
    localparam logic [7:0] CHR_LF = 8'h66;
    localparam logic [7:0] CHR_UA = 8'h41;
    localparam logic [7:0] CHR_UF = 8'h46;
    localparam int         MAX_REPORTS = 20;

    sed_pkg::t_phase  dec_phase;
    logic [15:0]      esc_value;
    logic [2:0]       esc_digits;
    logic [1:0]       lit_error;
    sed_pkg::t_result step_out[sed_pkg::MAX_RES];
    int               step_n;
    sed_pkg::t_result decoded_due[$];

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= CHR_0 && c <= CHR_9) return int'(c - CHR_0);
        if (c >= CHR_LA && c <= CHR_LF) return int'(c - CHR_LA) + 10;
        if (c >= CHR_UA && c <= CHR_UF) return int'(c - CHR_UA) + 10;
        return -1;
    endfunction

    function automatic void clear_literal();
        dec_phase  = sed_pkg::PH_PLAIN;
        esc_value  = '0;
        esc_digits = '0;
        lit_error  = sed_pkg::ERR_NONE;
    endfunction

    function automatic void queue_result(input sed_pkg::t_result r);
        decoded_due = {decoded_due, r};
    endfunction

    // bytes are suppressed once the literal has an error
    function automatic void push_byte(input logic [7:0] b);
        if (lit_error != sed_pkg::ERR_NONE || step_n >= sed_pkg::MAX_RES) return;
        step_out[step_n] = '{out_byte: b, byte_valid: 1'b1, end_of_literal: 1'b0,
                             error_code: sed_pkg::ERR_NONE};
        step_n++;
    endfunction

    function automatic void push_utf8(input logic [15:0] v);
        if (v < 16'h0080) begin
            push_byte(v[7:0]);
        end else if (v < 16'h0800) begin
            push_byte(8'hc0 | {3'b0, v[10:6]});
            push_byte(8'h80 | {2'b0, v[5:0]});
        end else begin
            push_byte(8'he0 | {4'b0, v[15:12]});
            push_byte(8'h80 | {2'b0, v[11:6]});
            push_byte(8'h80 | {2'b0, v[5:0]});
        end
    endfunction

    function automatic void raise_error(input logic [1:0] code);
        if (lit_error == sed_pkg::ERR_NONE) lit_error = code;
        dec_phase = sed_pkg::PH_DROP;
    endfunction

    function automatic void decode_escape(input logic [7:0] e);
        dec_phase = sed_pkg::PH_PLAIN;
        case (e)
            sed_pkg::CH_LC_N:   push_byte(sed_pkg::CH_NL);
            sed_pkg::CH_LC_T:   push_byte(sed_pkg::CTL_TAB);
            sed_pkg::CH_LC_R:   push_byte(sed_pkg::CTL_CR);
            sed_pkg::CH_LC_B:   push_byte(sed_pkg::CTL_BS);
            sed_pkg::CH_LC_F:   push_byte(sed_pkg::CTL_FF);
            sed_pkg::CH_LC_V:   push_byte(sed_pkg::CTL_VT);
            sed_pkg::CH_LC_A:   push_byte(sed_pkg::CTL_BEL);
            sed_pkg::CH_BSLASH: push_byte(sed_pkg::CH_BSLASH);
            sed_pkg::CH_QUOTE1: push_byte(sed_pkg::CH_QUOTE1);
            sed_pkg::CH_QUOTE2: push_byte(sed_pkg::CH_QUOTE2);
            sed_pkg::CH_NL:     ;
            sed_pkg::CH_LC_X: begin
                dec_phase  = sed_pkg::PH_HEX;
                esc_value  = '0;
                esc_digits = '0;
            end
            sed_pkg::CH_LC_U: begin
                dec_phase  = sed_pkg::PH_UNI;
                esc_value  = '0;
                esc_digits = '0;
            end
            default: begin
                if (e >= CHR_0 && e <= CHR_7) begin
                    dec_phase  = sed_pkg::PH_OCT;
                    esc_value  = {13'd0, e[2:0]};
                    esc_digits = 3'd1;
                end else begin
                    push_byte(sed_pkg::CH_BSLASH);
                    push_byte(e);
                end
            end
        endcase
    endfunction

    // one input byte -> step_out[0 .. step_n-1]
    function automatic void decode_byte(input logic [7:0] c, input logic last);
        int   h;
        logic as_text;
        as_text = 1'b0;
        step_n  = 0;
        h       = hex_digit_value(c);
        case (dec_phase)
            sed_pkg::PH_DROP: ;
            sed_pkg::PH_ESC:  decode_escape(c);
            sed_pkg::PH_OCT: begin
                if (c >= CHR_0 && c <= CHR_7) begin
                    esc_value = {esc_value[12:0], c[2:0]};
                    esc_digits++;
                    if (esc_digits >= 3'd3) begin
                        push_byte(esc_value[7:0]);
                        dec_phase = sed_pkg::PH_PLAIN;
                    end
                end else begin
                    push_byte(esc_value[7:0]);
                    dec_phase = sed_pkg::PH_PLAIN;
                    as_text   = 1'b1;
                end
            end
            sed_pkg::PH_HEX: begin
                if (h >= 0) begin
                    esc_value = {esc_value[11:0], h[3:0]};
                    esc_digits++;
                    if (esc_digits >= 3'd2) begin
                        push_byte(esc_value[7:0]);
                        dec_phase = sed_pkg::PH_PLAIN;
                    end
                end else if (esc_digits == 3'd0) begin
                    raise_error(sed_pkg::ERR_HEX);
                end else begin
                    push_byte(esc_value[7:0]);
                    dec_phase = sed_pkg::PH_PLAIN;
                    as_text   = 1'b1;
                end
            end
            sed_pkg::PH_UNI: begin
                if (h >= 0) begin
                    esc_value = {esc_value[11:0], h[3:0]};
                    esc_digits++;
                    if (esc_digits >= 3'd4) begin
                        push_utf8(esc_value);
                        dec_phase = sed_pkg::PH_PLAIN;
                    end
                end else begin
                    raise_error(sed_pkg::ERR_UNI);
                end
            end
            default: begin
                dec_phase = sed_pkg::PH_PLAIN;
                as_text   = 1'b1;
            end
        endcase
        if (as_text) begin
            if (c == sed_pkg::CH_BSLASH && !last) dec_phase = sed_pkg::PH_ESC;
            else push_byte(c);
        end
        if (last) begin
            case (dec_phase)
                sed_pkg::PH_OCT: push_byte(esc_value[7:0]);
                sed_pkg::PH_HEX: begin
                    if (esc_digits == 3'd0) raise_error(sed_pkg::ERR_HEX);
                    else push_byte(esc_value[7:0]);
                end
                sed_pkg::PH_UNI: raise_error(sed_pkg::ERR_UNI);
                default: ;
            endcase
            if (lit_error == sed_pkg::ERR_NONE && step_n > 0) begin
                step_out[step_n-1].end_of_literal = 1'b1;
            end else begin
                step_out[step_n] = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_literal: 1'b1,
                                     error_code: lit_error};
                step_n++;
            end
            clear_literal();
        end
    endfunction

    always @(posedge i_clk) begin
        sed_pkg::t_result got;
        sed_pkg::t_result want;
        if (!i_rst_n) begin
            clear_literal();
            decoded_due.delete();
            o_fail_count = 0;
            o_results    = 0;
            o_ends       = 0;
            o_errors     = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{out_byte: i_res.out_byte, byte_valid: i_res.byte_valid,
                        end_of_literal: i_res.end_of_literal, error_code: i_res.error_code};
                o_results++;
                if (got.end_of_literal) o_ends++;
                if (got.error_code != sed_pkg::ERR_NONE) o_errors++;
                if (decoded_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result byte=%02h bv=%b eol=%b err=%0d",
                                 $time, got.out_byte, got.byte_valid,
                                 got.end_of_literal, got.error_code);
                end else begin
                    want = decoded_due.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.end_of_literal !== want.end_of_literal ||
                        got.error_code !== want.error_code) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS)
                            $display({"%0t: mismatch exp byte=%02h bv=%b eol=%b err=%0d",
                                      " got byte=%02h bv=%b eol=%b err=%0d"}, $time,
                                     want.out_byte, want.byte_valid, want.end_of_literal,
                                     want.error_code, got.out_byte, got.byte_valid,
                                     got.end_of_literal, got.error_code);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                decode_byte(i_req.data_byte, i_req.is_last);
                for (int i = 0; i < step_n; i++) queue_result(step_out[i]);
            end
        end
        o_pending = decoded_due.size();
    end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Top of the string escape decoder testbench: clock, reset, literal stimulus with
// bursty requests, a stalling result sink, and the verdict from sed_decode_checker.
// Depends on sed_pkg, sed_req_if.sv, string_escape_decoder_top and the checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int RANDOM_BYTES = 210;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [1:0] RX_OPEN   = 2'd0;
    localparam logic [1:0] RX_COIN   = 2'd1;
    localparam logic [1:0] RX_SPARSE = 2'd2;
    localparam logic [1:0] RX_PULSE  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int results;
    int ends;
    int errors;

    int         bytes_sent;
    int         literals_sent;
    int         burst_left;
    logic       quiet_sender;
    logic [7:0] lit_buf[$];

    logic [1:0] rx_mode = RX_OPEN;
    int         rx_left = 0;
    logic [7:0] rx_tick = '0;

    sed_in_if  req_if ();
    sed_out_if res_if ();

    string_escape_decoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    sed_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_ends       (ends),
        .o_errors     (errors)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("** string_escape_decoder_top: FAILED **");
        $finish;
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = 2'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   res_if.ready <= 1'b1;
            RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
            RX_PULSE:  res_if.ready <= rx_tick[2];
            default:   res_if.ready <= 1'b1;
        endcase
    end

    function automatic void put_char(input logic [7:0] b);
        lit_buf = {lit_buf, b};
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_oct_char();
        return 8'h30 + 8'($urandom_range(0, 7));
    endfunction

    function automatic void add_random_segment();
        int    pick;
        int    n;
        string simple;
        pick   = $urandom_range(0, 99);
        simple = "ntrbfva\\'\"\n";
        if (pick < 30) begin
            if ($urandom_range(0, 9) < 7) put_char(8'($urandom_range(8'h20, 8'h7e)));
            else put_char(8'($urandom_range(0, 255)));
        end else if (pick < 45) begin
            put_char(sed_pkg::CH_BSLASH);
            put_char(simple[$urandom_range(0, simple.len() - 1)]);
        end else if (pick < 58) begin
            put_char(sed_pkg::CH_BSLASH);
            n = $urandom_range(1, 3);
            repeat (n) put_char(rand_oct_char());
        end else if (pick < 72) begin
            put_char(sed_pkg::CH_BSLASH);
            put_char(sed_pkg::CH_LC_X);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
            repeat (n) put_char(rand_hex_char());
        end else if (pick < 86) begin
            put_char(sed_pkg::CH_BSLASH);
            put_char(sed_pkg::CH_LC_U);
            n = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(0, 3);
            // bias the leading digits so all UTF-8 lengths show up
            for (int i = 0; i < n; i++) begin
                if (i < 2 && $urandom_range(0, 2) == 0) put_char(8'h30);
                else put_char(rand_hex_char());
            end
        end else if (pick < 93) begin
            put_char(sed_pkg::CH_BSLASH);
            put_char(8'($urandom_range(0, 255)));
        end else begin
            put_char(8'($urandom_range(0, 255)));
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = quiet_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid     <= 1'b1;
        req_if.data_byte <= b;
        req_if.is_last   <= last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_literal();
        quiet_sender = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < lit_buf.size(); i++) send_byte(lit_buf[i], i == lit_buf.size() - 1);
        lit_buf.delete();
        literals_sent++;
    endtask

    initial begin
        int random_start;
        req_if.valid     = 1'b0;
        req_if.data_byte = 8'h00;
        req_if.is_last   = 1'b0;
        bytes_sent       = 0;
        literals_sent    = 0;
        burst_left       = 0;
        quiet_sender     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // octal at its widest, wrapped to 8 bits
        add_text("\\777");
        send_literal();
        // \x with no digit: error, rest dropped
        add_text("\\xgA");
        send_literal();
        add_text("\\uffff");
        send_literal();
        // literal ends inside \u
        add_text("\\u12");
        send_literal();
        // unknown escape, extreme bytes, trailing backslash
        put_char(8'h00);
        add_text("\\q");
        put_char(8'hff);
        put_char(sed_pkg::CH_BSLASH);
        send_literal();
        // line continuation, octal cut short by a non-digit
        add_text("\\\n\\1z");
        send_literal();
        add_text("\\x");
        send_literal();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 6)) add_random_segment();
            send_literal();
        end
        req_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Drove %0d bytes in %0d literals; checked %0d results", bytes_sent,
                 literals_sent, results);
        $display("(%0d literal ends, %0d of them with an error code)", ends, errors);
        if (fail_count == 0 && pending == 0) begin
            $display("** string_escape_decoder_top: PASSED **");
        end else begin
            $display("** string_escape_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
